// ----- src/oversampled_serial_receiver_defines.svh -----
// Assertion macros used by the checker file of the serial receiver.
`ifndef OVERSAMPLED_SERIAL_RECEIVER_DEFINES_SVH
`define OVERSAMPLED_SERIAL_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define OSR_ASSERT_SAME(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("osr assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define OSR_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("osr assertion failed");

`endif

// ----- src/osr_pkg.sv -----
`default_nettype none

package osr_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_FRAME     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SAMPLE_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SPACING     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISCARD_BYTE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECEIVER_DISABLE   = 3'd4;

  // Register reset values.
  localparam logic [4:0] BITS_PER_FRAME_RST     = 5'd10;
  localparam logic [3:0] FIRST_SAMPLE_DELAY_RST = 4'd4;
  localparam logic [3:0] SAMPLE_SPACING_RST     = 4'd3;
  localparam logic [7:0] DISCARD_BYTE_RST       = 8'hC2;
  localparam logic       RECEIVER_DISABLE_RST   = 1'b0;

  // Width of the slot index on the result channel.
  localparam int SLOT_OUT_W = 4;

  typedef struct packed {
    logic [4:0] bits_per_frame;
    logic [3:0] first_sample_delay;
    logic [3:0] sample_spacing;
    logic [7:0] discard_byte;
    logic       receiver_disable;
  } osr_cfg_t;

  typedef struct packed {
    logic                  valid;
    logic [7:0]            received_byte;
    logic [SLOT_OUT_W-1:0] slot_index;
  } osr_result_t;

endpackage

`default_nettype wire

// ----- src/oversampled_serial_receiver.sv -----
// A tick request waits in the tick register; a byte it completes then loads the result register.
// Throughput: one tick per clock unless stalled; the tick and result registers each hold one request.
// A stalled result holds the tick register, so at most one more tick waits behind it.
// Reset (synchronous, rst_n low) clears the receive state and write slot to zero, empties
// both registers and loads the configuration defaults.
`default_nettype none

module oversampled_serial_receiver #(
  parameter int BUFFER_DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_rx_level,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [7:0]                          out_received_byte,
  output logic [osr_pkg::SLOT_OUT_W-1:0]      out_slot_index,
  input  wire logic                           cfg_write_en,
  input  wire logic [osr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [osr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import osr_pkg::*;

  osr_cfg_t    cfg;
  osr_result_t result;
  logic        advance;
  logic        tick_valid;
  logic        tick_level;

  // Configuration registers.
  osr_cfg_regs u_cfg_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  // Tick input register.
  osr_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_level (in_rx_level),
    .advance     (advance),
    .tick_valid  (tick_valid),
    .tick_level  (tick_level)
  );

  // Frame state machine, stepped when a tick moves into the result register.
  osr_frame_fsm #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_frame_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .step   (tick_valid && advance),
    .level  (tick_level),
    .result (result)
  );

  // Result register.
  osr_out_stage u_out_stage (
    .clk               (clk),
    .rst_n             (rst_n),
    .tick_valid        (tick_valid),
    .result            (result),
    .advance           (advance),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_received_byte (out_received_byte),
    .out_slot_index    (out_slot_index)
  );

endmodule

`default_nettype wire

// ----- src/osr_cfg_regs.sv -----
`default_nettype none

module osr_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_write_en,
  input  wire logic [osr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [osr_pkg::CFG_DATA_W-1:0] cfg_data,
  output osr_pkg::osr_cfg_t                   cfg
);
  import osr_pkg::*;

  osr_cfg_t cfg_r;
  osr_cfg_t cfg_nxt;

  // Decode the register index and mask the data to the register width.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write_en) begin
      case (cfg_index)
        REG_BITS_PER_FRAME:     cfg_nxt.bits_per_frame     = cfg_data[4:0];
        REG_FIRST_SAMPLE_DELAY: cfg_nxt.first_sample_delay = cfg_data[3:0];
        REG_SAMPLE_SPACING:     cfg_nxt.sample_spacing     = cfg_data[3:0];
        REG_DISCARD_BYTE:       cfg_nxt.discard_byte       = cfg_data[7:0];
        REG_RECEIVER_DISABLE:   cfg_nxt.receiver_disable   = cfg_data[0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bits_per_frame     <= BITS_PER_FRAME_RST;
      cfg_r.first_sample_delay <= FIRST_SAMPLE_DELAY_RST;
      cfg_r.sample_spacing     <= SAMPLE_SPACING_RST;
      cfg_r.discard_byte       <= DISCARD_BYTE_RST;
      cfg_r.receiver_disable   <= RECEIVER_DISABLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- src/osr_in_stage.sv -----
`default_nettype none

module osr_in_stage (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic in_rx_level,
  input  wire logic advance,
  output logic      tick_valid,
  output logic      tick_level
);

  logic valid_r;
  logic valid_nxt;
  logic level_r;
  logic take;

  // The stage holds one request; it stalls only when full and not draining.
  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Line level captured with the request; no reset needed.
  always_ff @(posedge clk) begin
    if (take) begin
      level_r <= in_rx_level;
    end
  end

  assign tick_valid = valid_r;
  assign tick_level = level_r;

endmodule

`default_nettype wire

// ----- src/osr_frame_fsm.sv -----
`default_nettype none

module osr_frame_fsm #(
  parameter int BUFFER_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire osr_pkg::osr_cfg_t  cfg,
  input  wire logic               step,
  input  wire logic               level,
  output osr_pkg::osr_result_t    result
);
  import osr_pkg::*;

  localparam int SLOT_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BUFFER_DEPTH - 1);

  // Receive phases; the unused code behaves as idle.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_BITS = 2'd1;
  localparam logic [1:0] PH_STOP = 2'd2;

  logic [1:0]        phase_r,  phase_nxt;
  logic [3:0]        cd_r,     cd_nxt;
  logic [4:0]        bits_r,   bits_nxt;
  logic [7:0]        shift_r,  shift_nxt;
  logic [7:0]        sel_r,    sel_nxt;
  logic [SLOT_W-1:0] slot_r,   slot_nxt;

  logic [3:0]               cd_dec;
  logic [4:0]               bits_dec;
  logic                     cd_hit;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

  assign cd_dec   = cd_r - 4'd1;
  assign cd_hit   = (cd_dec == 4'd0);
  assign bits_dec = bits_r - 5'd1;
  assign slot_ext = {{SLOT_OUT_W{1'b0}}, slot_r};

  // Next state and the result for the current tick.
  always_comb begin
    phase_nxt = phase_r;
    cd_nxt    = cd_r;
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    sel_nxt   = sel_r;
    slot_nxt  = slot_r;

    result.valid         = 1'b0;
    result.received_byte = shift_r;
    result.slot_index    = slot_ext[SLOT_OUT_W-1:0];

    if (step && !cfg.receiver_disable) begin
      case (phase_r)
        PH_STOP: begin
          cd_nxt = cd_dec;
          if (cd_hit) begin
            phase_nxt = PH_IDLE;
            if (shift_r != cfg.discard_byte) begin
              result.valid = 1'b1;
              slot_nxt     = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
            end
          end
        end
        PH_BITS: begin
          cd_nxt = cd_dec;
          if (cd_hit) begin
            cd_nxt   = cfg.sample_spacing;
            if (level) begin
              shift_nxt = shift_r | sel_r;
            end
            sel_nxt  = {sel_r[6:0], 1'b0};
            bits_nxt = bits_dec;
            if (bits_dec == 5'd0) begin
              phase_nxt = PH_STOP;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (!level) begin
            phase_nxt = PH_BITS;
            shift_nxt = 8'd0;
            cd_nxt    = cfg.first_sample_delay;
            bits_nxt  = cfg.bits_per_frame;
            sel_nxt   = 8'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cd_r    <= 4'd0;
      bits_r  <= 5'd0;
      shift_r <= 8'd0;
      sel_r   <= 8'd0;
      slot_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      cd_r    <= cd_nxt;
      bits_r  <= bits_nxt;
      shift_r <= shift_nxt;
      sel_r   <= sel_nxt;
      slot_r  <= slot_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/osr_out_stage.sv -----
`default_nettype none

module osr_out_stage (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                tick_valid,
  input  wire osr_pkg::osr_result_t                result,
  output logic                                     advance,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [7:0]                               out_received_byte,
  output logic [osr_pkg::SLOT_OUT_W-1:0]           out_slot_index
);
  import osr_pkg::*;

  logic                  valid_r;
  logic                  valid_nxt;
  logic [7:0]            byte_r;
  logic [SLOT_OUT_W-1:0] slot_r;

  // The register can load whenever it is empty or its request leaves now.
  assign advance   = !valid_r || !out_stall;
  assign valid_nxt = advance ? (tick_valid && result.valid) : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tick_valid && result.valid) begin
      byte_r <= result.received_byte;
      slot_r <= result.slot_index;
    end
  end

  assign out_valid         = valid_r;
  assign out_received_byte = byte_r;
  assign out_slot_index    = slot_r;

endmodule

`default_nettype wire

// ----- src/osr_checker.sv -----
`default_nettype none
`include "oversampled_serial_receiver_defines.svh"

module osr_prop_checker #(
  parameter int BUFFER_DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire logic [7:0]                     out_received_byte,
  input  wire logic [osr_pkg::SLOT_OUT_W-1:0] out_slot_index
);
  import osr_pkg::*;

  localparam int SLOT_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BUFFER_DEPTH - 1);

  logic [SLOT_W-1:0]            exp_slot_r;
  logic [SLOT_W-1:0]            exp_slot_nxt;
  logic [SLOT_W+SLOT_OUT_W-1:0] exp_slot_ext;
  logic                         in_take;
  logic                         out_take;

  assign in_take      = in_valid && !in_stall;
  assign out_take     = out_valid && !out_stall;
  assign exp_slot_ext = {{SLOT_OUT_W{1'b0}}, exp_slot_r};

  // Model of the write slot: it advances once per delivered byte.
  always_comb begin
    exp_slot_nxt = exp_slot_r;
    if (out_take) begin
      exp_slot_nxt = (exp_slot_r == SLOT_LAST) ? '0 : exp_slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_slot_r <= '0;
    end else begin
      exp_slot_r <= exp_slot_nxt;
    end
  end

  // Slots are handed out in ring order with no gap or repeat.
  `OSR_ASSERT_SAME(a_slot_order, out_valid, out_slot_index == exp_slot_ext[SLOT_OUT_W-1:0])

  // A held result keeps its payload.
  `OSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_received_byte) && $stable(out_slot_index))

  // A new result always comes from an earlier accepted tick, held in the tick register first.
  `OSR_ASSERT_SAME(a_out_source, $rose(out_valid), $past(in_take, 2))

endmodule

bind oversampled_serial_receiver osr_prop_checker #(
  .BUFFER_DEPTH (BUFFER_DEPTH)
) u_osr_prop_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_received_byte (out_received_byte),
  .out_slot_index    (out_slot_index)
);

`default_nettype wire
